/* design/atr_pkg.sv */
// Shared types and codes for the answer-to-reset byte parser.
// Used by atr_classify and smartcard_atr_parser_unit; depends on nothing.
package atr_pkg;

    localparam int MAX_GROUPS_DEFAULT = 8;

    localparam logic [7:0] TS_DIRECT  = 8'h3B;
    localparam logic [7:0] TS_INVERSE = 8'h3F;

    typedef enum logic [3:0] {
        PH_TS   = 4'd0,
        PH_T0   = 4'd1,
        PH_TA   = 4'd2,
        PH_TB   = 4'd3,
        PH_TC   = 4'd4,
        PH_TD   = 4'd5,
        PH_HIST = 4'd6,
        PH_TCK  = 4'd7,
        PH_DONE = 4'd8
    } phase_t;

    localparam logic [3:0] KIND_TS      = 4'd0;
    localparam logic [3:0] KIND_T0      = 4'd1;
    localparam logic [3:0] KIND_TA      = 4'd2;
    localparam logic [3:0] KIND_TB      = 4'd3;
    localparam logic [3:0] KIND_TC      = 4'd4;
    localparam logic [3:0] KIND_TD      = 4'd5;
    localparam logic [3:0] KIND_HIST    = 4'd6;
    localparam logic [3:0] KIND_TCK     = 4'd7;
    localparam logic [3:0] KIND_IGNORED = 4'd8;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVERSE     = 3'd1;
    localparam logic [2:0] ST_INVALID_TS  = 3'd2;
    localparam logic [2:0] ST_CHECKSUM    = 3'd3;
    localparam logic [2:0] ST_GROUPS      = 3'd4;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_buffer;
    } atr_in_t;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic [3:0] byte_kind;
        logic [2:0] group_index;
        logic [3:0] hist_position;
        logic [3:0] hist_total;
        logic [3:0] protocol_type;
        logic [2:0] status;
        logic       complete;
    } atr_out_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] pending_presence;
        logic [3:0] group_count;
        logic [3:0] hist_count_total;
        logic [3:0] hist_seen;
        logic [3:0] protocol_seen;
        logic [7:0] running_xor;
        logic [2:0] error_code;
    } atr_state_t;

endpackage

/* design/smartcard_atr_parser_unit.sv */
// Top level of the answer-to-reset byte parser: input register, state, result register.
// Depends on atr_pkg and atr_classify.
//
//  channel   valid          stall          word
//  byte      byte_valid     byte_stall     byte_word   (atr_in_t, byte + end flag)
//  result    result_valid   result_stall   result_word (atr_out_t, one per byte)
//
// Each byte is captured in the input register, classified combinationally and lands
// in the result register; a stalled result can hold it back in the input register.
// The classify logic and state update sit between the two registers.
// Reset clears the parser state and both valid flags; the parser is ready at once.
// A stalled result holds the pipeline; byte_stall rises only while both registers
// hold a word and the result side stalls.
module smartcard_atr_parser_unit #(
    parameter int MAX_GROUPS = atr_pkg::MAX_GROUPS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  atr_pkg::atr_in_t  byte_word,
    output logic              result_valid,
    input  logic              result_stall,
    output atr_pkg::atr_out_t result_word
);

    logic                in_valid_reg;
    logic                in_valid_next;
    atr_pkg::atr_in_t    in_word_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    atr_pkg::atr_out_t   out_word_reg;
    atr_pkg::atr_state_t state_reg;
    atr_pkg::atr_state_t state_next;
    atr_pkg::atr_out_t   result_next;

    logic advance;
    logic take;

    atr_classify #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_classify (
        .cur  (state_reg),
        .item (in_word_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // move the input word into the result register when that register frees up
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall = in_valid_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_word_reg <= byte_word;
        if (advance)
            out_word_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule

/* design/atr_classify.sv */
// Per-byte classification and parser state update, purely combinational.
// Depends on atr_pkg for the state, word and code definitions.
module atr_classify #(
    parameter int MAX_GROUPS = atr_pkg::MAX_GROUPS_DEFAULT
) (
    input  atr_pkg::atr_state_t cur,
    input  atr_pkg::atr_in_t    item,
    output atr_pkg::atr_state_t nxt,
    output atr_pkg::atr_out_t   res
);

    localparam logic [4:0] GROUP_LIMIT = 5'(MAX_GROUPS);

    // Phase after the interface bytes, or the next interface byte present.
    function automatic atr_pkg::phase_t from_presence(
        input logic [3:0] y,
        input logic [3:0] hist_total,
        input logic [3:0] protocol
    );
        atr_pkg::phase_t ph;
        begin
            if (y[0])
                ph = atr_pkg::PH_TA;
            else if (y[1])
                ph = atr_pkg::PH_TB;
            else if (y[2])
                ph = atr_pkg::PH_TC;
            else if (y[3])
                ph = atr_pkg::PH_TD;
            else if (hist_total != 4'd0)
                ph = atr_pkg::PH_HIST;
            else if (protocol != 4'd0)
                ph = atr_pkg::PH_TCK;
            else
                ph = atr_pkg::PH_DONE;
            return ph;
        end
    endfunction

    logic [7:0] b;
    logic [3:0] kind;
    logic [3:0] grp;
    logic [3:0] hpos;
    logic [3:0] seen_inc;

    assign b        = item.byte_value;
    assign seen_inc = cur.hist_seen + 4'd1;

    always_comb
    begin
        nxt  = cur;
        kind = atr_pkg::KIND_IGNORED;
        grp  = 4'd0;
        hpos = 4'd0;

        if (cur.phase != atr_pkg::PH_TS && cur.phase < atr_pkg::PH_DONE)
            nxt.running_xor = cur.running_xor ^ b;

        case (cur.phase)
            atr_pkg::PH_TS:
            begin
                kind = atr_pkg::KIND_TS;
                if (b == atr_pkg::TS_DIRECT)
                    nxt.phase = atr_pkg::PH_T0;
                else
                begin
                    nxt.error_code = (b == atr_pkg::TS_INVERSE) ? atr_pkg::ST_INVERSE
                                                                : atr_pkg::ST_INVALID_TS;
                    nxt.phase = atr_pkg::PH_DONE;
                end
            end
            atr_pkg::PH_T0:
            begin
                kind = atr_pkg::KIND_T0;
                nxt.hist_count_total = b[3:0];
                nxt.pending_presence = b[7:4];
                nxt.phase = from_presence(b[7:4], b[3:0], cur.protocol_seen);
            end
            atr_pkg::PH_TA, atr_pkg::PH_TB, atr_pkg::PH_TC:
            begin
                grp = cur.group_count;
                // drop this byte's presence bit and every lower one
                if (cur.phase == atr_pkg::PH_TA)
                begin
                    kind = atr_pkg::KIND_TA;
                    nxt.pending_presence = cur.pending_presence & 4'b1110;
                end
                else if (cur.phase == atr_pkg::PH_TB)
                begin
                    kind = atr_pkg::KIND_TB;
                    nxt.pending_presence = cur.pending_presence & 4'b1100;
                end
                else
                begin
                    kind = atr_pkg::KIND_TC;
                    nxt.pending_presence = cur.pending_presence & 4'b1000;
                end
                nxt.phase = from_presence(nxt.pending_presence, cur.hist_count_total,
                                          cur.protocol_seen);
            end
            atr_pkg::PH_TD:
            begin
                kind = atr_pkg::KIND_TD;
                grp  = cur.group_count;
                if (cur.group_count == 4'd0)
                    nxt.protocol_seen = b[3:0];
                nxt.pending_presence = b[7:4];
                if (b[7:4] != 4'd0 && ({1'b0, cur.group_count} + 5'd1) >= GROUP_LIMIT)
                begin
                    nxt.error_code = atr_pkg::ST_GROUPS;
                    nxt.phase = atr_pkg::PH_DONE;
                end
                else
                begin
                    if (cur.group_count != 4'd15)
                        nxt.group_count = cur.group_count + 4'd1;
                    nxt.phase = from_presence(b[7:4], cur.hist_count_total,
                                              nxt.protocol_seen);
                end
            end
            atr_pkg::PH_HIST:
            begin
                kind = atr_pkg::KIND_HIST;
                hpos = cur.hist_seen;
                nxt.hist_seen = seen_inc;
                if (seen_inc == cur.hist_count_total)
                    nxt.phase = (cur.protocol_seen != 4'd0) ? atr_pkg::PH_TCK
                                                            : atr_pkg::PH_DONE;
            end
            atr_pkg::PH_TCK:
            begin
                kind = atr_pkg::KIND_TCK;
                if (nxt.running_xor != 8'd0)
                    nxt.error_code = atr_pkg::ST_CHECKSUM;
                nxt.phase = atr_pkg::PH_DONE;
            end
            default:
            begin
                kind = atr_pkg::KIND_IGNORED;
            end
        endcase

        res.echo_byte     = b;
        res.byte_kind     = kind;
        res.group_index   = grp[2:0];
        res.hist_position = hpos;
        res.hist_total    = nxt.hist_count_total;
        res.protocol_type = nxt.protocol_seen;
        res.status        = nxt.error_code;
        res.complete      = (nxt.phase >= atr_pkg::PH_DONE) || item.end_of_buffer;

        // end of buffer: return to the reset state after this word
        if (item.end_of_buffer)
            nxt = '0;
    end

endmodule
